### rtl/core/multi_led_blink_pattern_generator_assert.svh
// assertion macros for the blink generator checker
// no dependencies; clock and reset are taken from the including scope (clk, rst_n)
`ifndef MULTI_LED_BLINK_PATTERN_GENERATOR_ASSERT_SVH
`define MULTI_LED_BLINK_PATTERN_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MLBPG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blink generator assertion failed");

// next-cycle implication, disabled while in reset
`define MLBPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blink generator assertion failed");

`endif

### rtl/core/mlbpg_pkg.sv
// shared types and constants of the multi-channel led blink generator
// no dependencies
package mlbpg_pkg;

    localparam int NUM_CHANNELS_DEF = 3;
    localparam int MAX_CHANNELS     = 4;
    localparam int REPORT_CHANNELS  = 3;
    localparam int IDX_W            = 2;
    localparam int TIME_W           = 16;
    localparam int REQ_W            = 3;

    localparam logic [REQ_W-1:0] REQ_TICK      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FORCE_ON  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FORCE_OFF = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TOGGLE    = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [IDX_W-1:0]  led_index;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
        logic [TIME_W-1:0] repeat_count;
    } req_t;

    typedef struct packed {
        logic                       accepted;
        logic [REPORT_CHANNELS-1:0] busy_flags;
        logic [REPORT_CHANNELS-1:0] pin_levels;
    } rsp_t;

    // per-channel command strobes, asserted only in the cycle the word is processed
    typedef struct packed {
        logic tick;
        logic start;
        logic force_on;
        logic force_off;
        logic toggle;
    } chan_cmd_t;

endpackage

### rtl/core/mlbpg_channel.sv
// one blink channel: period counters, repeat count and pin level
// depends on mlbpg_pkg
module mlbpg_channel
    import mlbpg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  chan_cmd_t         cmd,
    input  logic [TIME_W-1:0] on_time,
    input  logic [TIME_W-1:0] off_time,
    input  logic [TIME_W-1:0] repeat_count,
    output logic              busy,
    output logic              busy_next,
    output logic              pin_next
);

    logic [TIME_W-1:0] rep_reg, rep_next;
    logic [TIME_W-1:0] on_rld_reg, on_rld_next;
    logic [TIME_W-1:0] off_rld_reg, off_rld_next;
    logic [TIME_W-1:0] on_rem_reg, on_rem_next;
    logic [TIME_W-1:0] off_rem_reg, off_rem_next;
    logic              pin_reg, pin_next_int;
    logic              load_ok;

    assign busy    = (rep_reg != '0);
    assign load_ok = (on_time != '0) && (off_time != '0) && (repeat_count != '0);

    always_comb
    begin
        rep_next     = rep_reg;
        on_rld_next  = on_rld_reg;
        off_rld_next = off_rld_reg;
        on_rem_next  = on_rem_reg;
        off_rem_next = off_rem_reg;
        pin_next_int = pin_reg;
        if (cmd.tick)
        begin
            if (busy)
            begin
                if (on_rem_reg != '0)
                begin
                    on_rem_next  = on_rem_reg - 1'b1;
                    pin_next_int = 1'b0;
                end
                else if (off_rem_reg != '0)
                begin
                    off_rem_next = off_rem_reg - 1'b1;
                    pin_next_int = 1'b1;
                end
                else
                begin
                    // end of period: spend this tick on the reload
                    rep_next     = rep_reg - 1'b1;
                    on_rem_next  = on_rld_reg;
                    off_rem_next = off_rld_reg;
                end
            end
        end
        else if (cmd.start)
        begin
            if (!busy && load_ok)
            begin
                rep_next     = repeat_count;
                on_rld_next  = on_time;
                on_rem_next  = on_time;
                off_rld_next = off_time;
                off_rem_next = off_time;
                pin_next_int = 1'b0;
            end
        end
        else if (cmd.force_on)
        begin
            pin_next_int = 1'b0;
        end
        else if (cmd.force_off)
        begin
            pin_next_int = 1'b1;
        end
        else if (cmd.toggle)
        begin
            pin_next_int = ~pin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_reg     <= '0;
            on_rld_reg  <= '0;
            off_rld_reg <= '0;
            on_rem_reg  <= '0;
            off_rem_reg <= '0;
            pin_reg     <= 1'b1;
        end
        else
        begin
            rep_reg     <= rep_next;
            on_rld_reg  <= on_rld_next;
            off_rld_reg <= off_rld_next;
            on_rem_reg  <= on_rem_next;
            off_rem_reg <= off_rem_next;
            pin_reg     <= pin_next_int;
        end
    end

    assign busy_next = (rep_next != '0);
    assign pin_next  = pin_next_int;

endmodule

### rtl/core/multi_led_blink_pattern_generator.sv
// Multi-channel LED blink generator, top level.
// Depends on mlbpg_pkg and mlbpg_channel.
//
// Input channel req/req_valid/req_ready carries one request word: tick, start
// blink, force on, force off or toggle, with channel index and blink times.
// Output channel rsp/rsp_valid/rsp_ready returns exactly one word per request:
// the start accept flag and the busy and pin levels of channels 0 to 2 after
// the request took effect (pins are active low, 0 means lit).
// A request is registered in the input register on acceptance and processed from
// there into the result register, which holds its result word.
// Throughput: one request per cycle; all channels update in parallel from the
// input register into the result register, so req_ready stays high while the
// result register is empty or being drained.
// When the receiver stalls, the result word is held and one more request is
// buffered in the input register; after that req_ready drops.
// Reset clears all counters, marks every channel idle and drives all pins dark.
module multi_led_blink_pattern_generator
    import mlbpg_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic        s1_valid_reg, s1_valid_next;
    req_t        s1_req_reg;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    logic        out_free;
    logic        advance;
    logic        is_tick, is_start, is_fon, is_foff, is_tgl;

    logic [NUM_CHANNELS-1:0] busy_now;
    logic [NUM_CHANNELS-1:0] busy_nxt;
    logic [NUM_CHANNELS-1:0] pin_nxt;
    logic [NUM_CHANNELS-1:0] start_ok;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign advance   = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;

    always_comb
    begin
        is_tick  = 1'b0;
        is_start = 1'b0;
        is_fon   = 1'b0;
        is_foff  = 1'b0;
        is_tgl   = 1'b0;
        case (s1_req_reg.req_type)
            REQ_TICK:      is_tick  = advance;
            REQ_START:     is_start = advance;
            REQ_FORCE_ON:  is_fon   = advance;
            REQ_FORCE_OFF: is_foff  = advance;
            REQ_TOGGLE:    is_tgl   = advance;
            default:       is_tick  = 1'b0;
        endcase
    end

    genvar c;
    generate
        for (c = 0; c < NUM_CHANNELS; c++)
        begin : g_chan
            chan_cmd_t cmd;
            logic      hit;

            assign hit           = (s1_req_reg.led_index == IDX_W'(c));
            assign cmd.tick      = is_tick;
            assign cmd.start     = is_start && hit;
            assign cmd.force_on  = is_fon && hit;
            assign cmd.force_off = is_foff && hit;
            assign cmd.toggle    = is_tgl && hit;
            assign start_ok[c]   = cmd.start && !busy_now[c];

            mlbpg_channel u_chan (
                .clk          (clk),
                .rst_n        (rst_n),
                .cmd          (cmd),
                .on_time      (s1_req_reg.on_time),
                .off_time     (s1_req_reg.off_time),
                .repeat_count (s1_req_reg.repeat_count),
                .busy         (busy_now[c]),
                .busy_next    (busy_nxt[c]),
                .pin_next     (pin_nxt[c])
            );
        end

        // channels past the report width are not shown; missing ones read as zero
        for (c = 0; c < REPORT_CHANNELS; c++)
        begin : g_report
            if (c < NUM_CHANNELS)
            begin : g_have
                assign rsp_next.busy_flags[c] = busy_nxt[c];
                assign rsp_next.pin_levels[c] = pin_nxt[c];
            end
            else
            begin : g_none
                assign rsp_next.busy_flags[c] = 1'b0;
                assign rsp_next.pin_levels[c] = 1'b0;
            end
        end
    endgenerate

    // an out-of-range index matches no channel, so it is never accepted
    assign rsp_next.accepted = |start_ok;

    assign s1_valid_next  = req_ready ? req_valid : s1_valid_reg;
    assign rsp_valid_next = out_free ? s1_valid_reg : rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/core/mlbpg_checker.sv
// port-level checker for the blink generator, bound to the top level
// depends on mlbpg_pkg and multi_led_blink_pattern_generator_assert.svh
`include "multi_led_blink_pattern_generator_assert.svh"

module mlbpg_checker
    import mlbpg_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    logic req_seen;

    // request payload only matters alongside its valid
    assign req_seen = req_valid && (req.req_type == REQ_TICK || req.req_type != REQ_TICK);

    // a stalled result word holds
    `MLBPG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // a draining output always makes room for a new request word
    `MLBPG_ASSERT_SAME(a_ready_on_drain, rsp_ready, req_ready)

    // with the output empty the input side can never be blocked
    `MLBPG_ASSERT_SAME(a_ready_on_empty, !rsp_valid, req_ready)

    // a request taken with the output empty shows up as a result via the input register
    `MLBPG_ASSERT_NEXT(a_result_follows, req_seen && req_ready && !rsp_valid,
                       ##1 rsp_valid)

endmodule

bind multi_led_blink_pattern_generator mlbpg_checker u_mlbpg_checker (.*);

### tb/multi_led_blink_pattern_generator_tb.sv
// self-checking testbench for the multi-channel led blink generator
// depends on mlbpg_pkg and multi_led_blink_pattern_generator; keeps its own model of the channel bank
module multi_led_blink_pattern_generator_tb
    import mlbpg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH       = NUM_CHANNELS_DEF;
    localparam int REAL_ITEMS   = 1500;
    localparam int CALM_ITEMS   = 1300;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REQ_BITS     = $bits(req_t);

    localparam logic [REQ_W-1:0] REQ_BAD_LO = REQ_TOGGLE + 3'd1;
    localparam logic [REQ_W-1:0] REQ_BAD_HI = '1;
    localparam logic [TIME_W-1:0] TIME_MAX  = '1;

    // bank of blink channels, predicted one request word at a time
    class led_bank_model;
        logic [TIME_W-1:0] repeats_left [NUM_CH];
        logic [TIME_W-1:0] on_reload    [NUM_CH];
        logic [TIME_W-1:0] off_reload   [NUM_CH];
        logic [TIME_W-1:0] on_left      [NUM_CH];
        logic [TIME_W-1:0] off_left     [NUM_CH];
        logic              pin          [NUM_CH];
        rsp_t              pending_status [$];
        int                errors;

        function new();
            errors = 0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                repeats_left[c] = '0;
                on_reload[c]    = '0;
                off_reload[c]   = '0;
                on_left[c]      = '0;
                off_left[c]     = '0;
                pin[c]          = 1'b1;
            end
        endfunction

        function void advance_tick();
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (repeats_left[c] != 0)
                begin
                    if (on_left[c] != 0)
                    begin
                        on_left[c] = on_left[c] - 1'b1;
                        pin[c]     = 1'b0;
                    end
                    else if (off_left[c] != 0)
                    begin
                        off_left[c] = off_left[c] - 1'b1;
                        pin[c]      = 1'b1;
                    end
                    else
                    begin
                        // end of a period: pin keeps its level for this tick
                        repeats_left[c] = repeats_left[c] - 1'b1;
                        on_left[c]      = on_reload[c];
                        off_left[c]     = off_reload[c];
                    end
                end
            end
        endfunction

        function void note_request(req_t w);
            rsp_t status;
            int   ch;
            status = '0;
            ch     = w.led_index;
            if (w.req_type == REQ_TICK)
                advance_tick();
            else if (w.req_type <= REQ_TOGGLE && ch < NUM_CH)
            begin
                case (w.req_type)
                    REQ_START:
                    begin
                        if (repeats_left[ch] == 0)
                        begin
                            status.accepted = 1'b1;
                            if (w.repeat_count != 0 && w.on_time != 0 && w.off_time != 0)
                            begin
                                repeats_left[ch] = w.repeat_count;
                                on_reload[ch]    = w.on_time;
                                on_left[ch]      = w.on_time;
                                off_reload[ch]   = w.off_time;
                                off_left[ch]     = w.off_time;
                                pin[ch]          = 1'b0;
                            end
                        end
                    end
                    REQ_FORCE_ON:  pin[ch] = 1'b0;
                    REQ_FORCE_OFF: pin[ch] = 1'b1;
                    default:       pin[ch] = ~pin[ch];
                endcase
            end
            for (int c = 0; c < NUM_CH && c < REPORT_CHANNELS; c++)
            begin
                status.busy_flags[c] = (repeats_left[c] != 0);
                status.pin_levels[c] = pin[c];
            end
            pending_status.push_back(status);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_status.size() == 0)
            begin
                $error("result word with nothing expected: %h", got);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            if (got.accepted !== want.accepted)
            begin
                $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
                errors++;
            end
            if (got.busy_flags !== want.busy_flags)
            begin
                $error("busy_flags: expected %b, got %b", want.busy_flags, got.busy_flags);
                errors++;
            end
            if (got.pin_levels !== want.pin_levels)
            begin
                $error("pin_levels: expected %b, got %b", want.pin_levels, got.pin_levels);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_status.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    led_bank_model book = new();
    int  cycle_count = 0;
    bit  calm = 1'b0;
    int  stall_left = 0;
    int  rx_cycles = 0;
    bit  rx_bursty = 1'b1;

    multi_led_blink_pattern_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            book.check_result(rsp);
    end

    // receiver stalls in bursts, with quiet stretches in between
    always @(negedge clk)
    begin
        rx_cycles++;
        if (rx_cycles % 200 == 0)
            rx_bursty = ($urandom_range(0, 2) != 0);
        if (stall_left != 0)
            stall_left--;
        else if (rst_n && !calm && rx_bursty && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 12);
        rsp_ready <= (stall_left == 0);
    end

    function automatic req_t make_request(logic [REQ_W-1:0] kind, int ch,
                                          int on_t, int off_t, int reps);
        req_t w;
        w.req_type     = kind;
        w.led_index    = IDX_W'(ch);
        w.on_time      = TIME_W'(on_t);
        w.off_time     = TIME_W'(off_t);
        w.repeat_count = TIME_W'(reps);
        return w;
    endfunction

    function automatic bit is_ignored(req_t w);
        return (w.req_type > REQ_TOGGLE) ||
               (w.req_type != REQ_TICK && w.led_index >= NUM_CH);
    endfunction

    function automatic req_t random_request();
        req_t w;
        int   pick;
        int   which;
        // payload is full range on all but start requests, so all field bits get exercised
        w.on_time      = TIME_W'($urandom);
        w.off_time     = TIME_W'($urandom);
        w.repeat_count = TIME_W'($urandom);
        w.led_index    = ($urandom_range(0, 9) == 0) ? IDX_W'(3)
                                                     : IDX_W'($urandom_range(0, NUM_CH - 1));
        pick = $urandom_range(0, 99);
        if (pick < 55)
            w.req_type = REQ_TICK;
        else if (pick < 77)
        begin
            w.req_type = REQ_START;
            if ($urandom_range(0, 9) == 0)
            begin
                // one field zero: accepted on an idle channel, loads nothing
                which = $urandom_range(0, 2);
                if (which == 0)
                    w.on_time = '0;
                else if (which == 1)
                    w.off_time = '0;
                else
                    w.repeat_count = '0;
            end
            else
            begin
                w.on_time      = TIME_W'($urandom_range(1, 4));
                w.off_time     = TIME_W'($urandom_range(1, 4));
                w.repeat_count = TIME_W'($urandom_range(1, 3));
            end
        end
        else if (pick < 85)
            w.req_type = REQ_FORCE_ON;
        else if (pick < 92)
            w.req_type = REQ_FORCE_OFF;
        else if (pick < 97)
            w.req_type = REQ_TOGGLE;
        else
            w.req_type = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        return w;
    endfunction

    task automatic send_request(input req_t w);
        @(negedge clk);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        book.note_request(w);
    endtask

    task automatic hold_off(input int n);
        @(negedge clk);
        req_valid <= 1'b0;
        req       <= req_t'(REQ_BITS'({$urandom, $urandom}));
        repeat (n - 1)
            @(negedge clk);
    endtask

    initial
    begin
        req_t directed [$];
        req_t w;
        int   real_items;
        bit   tx_bursty;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        real_items = 0;
        tx_bursty  = 1'b1;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // shortest blink through a full period, zero-field starts, refused start,
        // forcing during a blink, out-of-range index and unknown request codes
        directed.push_back(make_request(REQ_TICK, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_START, 0, 1, 1, 1));
        directed.push_back(make_request(REQ_TICK, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_TICK, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_TICK, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_START, 0, 0, 5, 3));
        directed.push_back(make_request(REQ_START, 1, TIME_MAX, TIME_MAX, 0));
        directed.push_back(make_request(REQ_START, 2, TIME_MAX, 0, TIME_MAX));
        directed.push_back(make_request(REQ_START, 2, 2, 3, 2));
        directed.push_back(make_request(REQ_START, 2, TIME_MAX, TIME_MAX, TIME_MAX));
        directed.push_back(make_request(REQ_FORCE_OFF, 2, 0, 0, 0));
        directed.push_back(make_request(REQ_TICK, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_TOGGLE, 2, 0, 0, 0));
        directed.push_back(make_request(REQ_TICK, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_FORCE_ON, 1, 0, 0, 0));
        directed.push_back(make_request(REQ_FORCE_OFF, 1, 0, 0, 0));
        directed.push_back(make_request(REQ_TOGGLE, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_TOGGLE, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_START, 3, 1, 1, 1));
        directed.push_back(make_request(REQ_FORCE_ON, 3, 0, 0, 0));
        directed.push_back(make_request(REQ_TOGGLE, 3, 0, 0, 0));
        directed.push_back(make_request(REQ_BAD_LO, 0, 1, 1, 1));
        directed.push_back(make_request(REQ_BAD_HI, 1, TIME_MAX, TIME_MAX, TIME_MAX));
        directed.push_back(make_request(REQ_TICK, 0, 0, 0, 0));
        directed.push_back(make_request(REQ_TICK, 0, 0, 0, 0));
        foreach (directed[i])
            send_request(directed[i]);

        while (real_items < REAL_ITEMS)
        begin
            if (real_items % 64 == 0)
                tx_bursty = ($urandom_range(0, 2) != 0);
            if (real_items >= CALM_ITEMS)
                calm = 1'b1;
            if (!calm && tx_bursty && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 12));
            w = random_request();
            send_request(w);
            if (!is_ignored(w))
                real_items++;
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (book.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
